@@ hw/rtl/rcht_pkg.sv @@
package rcht_pkg;

    localparam int MAIN_ENTRIES_DEF  = 32768;
    localparam int COLL_WORDS_DEF    = 8192;
    localparam int COLL_HEADROOM_DEF = 16;
    localparam int OVFL_ENTRIES_DEF  = 64;

    localparam logic [15:0] CNT_MASK     = 16'hFC00;
    localparam logic [15:0] CNT_STK_MASK = 16'hFE00;
    localparam logic [15:0] STK_BIT      = 16'h0200;
    localparam logic [15:0] CNT_ONE      = 16'h0400;
    localparam logic [15:0] CNT_TWO      = 16'h0800;
    localparam logic [15:0] LOW_MASK     = 16'h03FF;
    localparam logic [15:0] CNT_FALL     = 16'hF800;
    localparam logic [31:0] BIG_LIMIT    = 32'd63;
    localparam logic [31:0] BIG_DUP      = 32'h0001_0000;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;
    localparam logic [1:0] CMD_STK = 2'd2;
    localparam logic [1:0] CMD_BAD = 2'd3;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_STACK     = 3'd1;
    localparam logic [2:0] ERR_ZERO_DEC  = 3'd2;
    localparam logic [2:0] ERR_OVFL_DUP  = 3'd3;
    localparam logic [2:0] ERR_OVFL_MISS = 3'd4;
    localparam logic [2:0] ERR_OVFL_FULL = 3'd5;
    localparam logic [2:0] ERR_COLL_FULL = 3'd6;

    localparam logic [1:0] OTAG_END  = 2'd0;
    localparam logic [1:0] OTAG_FREE = 2'd1;
    localparam logic [1:0] OTAG_USED = 2'd2;

    typedef enum logic [2:0] {
        ACT_WRITE,
        ACT_BIG_ENTER,
        ACT_BIG_MOD,
        ACT_REMOVE,
        ACT_ERROR
    } mod_act_t;

    typedef struct packed {
        mod_act_t    act;
        logic [15:0] word;
        logic [2:0]  err;
    } mod_res_t;

    typedef struct packed {
        logic [1:0]  tag;
        logic [23:0] ptr;
        logic [31:0] cnt;
    } ovfl_t;

    typedef enum logic [1:0] {
        GLM_COLL1,
        GLM_COLL2,
        GLM_TAIL
    } gl_mode_t;

    function automatic mod_res_t mod_entry(logic [15:0] w, logic [1:0] cmd, logic rec);
        mod_res_t    r;
        logic [15:0] c2;
        logic        chk;
        r.act  = ACT_WRITE;
        r.word = w;
        r.err  = ERR_OK;
        c2     = w;
        chk    = 1'b0;
        if (w >= CNT_MASK) begin
            r.act = ACT_BIG_MOD;
        end else begin
            unique case (cmd)
                CMD_ADD: begin
                    c2 = w + CNT_ONE;
                    if (c2 >= CNT_MASK) begin
                        r.act  = ACT_BIG_ENTER;
                        r.word = c2;
                    end else begin
                        chk = 1'b1;
                    end
                end
                CMD_DEL: begin
                    if (w < CNT_ONE) begin
                        r.act = ACT_ERROR;
                        r.err = ERR_ZERO_DEC;
                    end else begin
                        c2  = w - CNT_ONE;
                        chk = 1'b1;
                    end
                end
                CMD_STK: begin
                    if (!rec) begin
                        r.act = ACT_ERROR;
                        r.err = ERR_STACK;
                    end else begin
                        r.word = w | STK_BIT;
                    end
                end
                default: begin
                    r.act = ACT_ERROR;
                    r.err = ERR_STACK;
                end
            endcase
        end
        if (chk) begin
            if ((c2 & CNT_STK_MASK) == CNT_ONE) begin
                r.act = ACT_REMOVE;
            end else begin
                r.word = c2;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] new_value(logic [1:0] cmd, logic [7:0] tag);
        logic [15:0] hi;
        hi = {7'd0, tag, 1'b0};
        unique case (cmd)
            CMD_ADD: return hi | CNT_TWO;
            CMD_DEL: return hi;
            default: return hi | CNT_ONE | STK_BIT;
        endcase
    endfunction

endpackage

@@ hw/rtl/refcount_hash_table.sv @@
// Channel  | Ports                     | Payload
// s_ input | s_tvalid s_tready s_tdata | one request
// m_ out   | m_tvalid m_tready m_tdata | one result per request
//
// After reset a clearing pass over max(MAIN_ENTRIES, OVFL_ENTRIES) addresses zeroes the main
// table and the overflow tags; no request is taken meanwhile.
// A request reads its main entry, then as needed walks collision links, takes links (from the
// free list when it is not empty, else from the high-water mark), writes new links, unlinks a
// removed link through ST_RM_A, ST_RM_B and ST_RM_C, and searches the overflow slots in turn.
// One request is in work at a time; a result not yet taken holds the next one in its last
// cycle, and s_tready stays low until that result moves into the output register.
module refcount_hash_table #(
    parameter int MAIN_ENTRIES  = rcht_pkg::MAIN_ENTRIES_DEF,
    parameter int COLL_WORDS    = rcht_pkg::COLL_WORDS_DEF,
    parameter int COLL_HEADROOM = rcht_pkg::COLL_HEADROOM_DEF,
    parameter int OVFL_ENTRIES  = rcht_pkg::OVFL_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cmd[1:0], pointer[25:2], reclaim_phase[26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // zero_entry_valid[0], zero_pointer[24:1],
                                   // error_code[27:25], gc_off[28]
);

    localparam int MI_W  = $clog2(MAIN_ENTRIES);
    localparam int CI_W  = $clog2(COLL_WORDS / 2);
    localparam int OI_W  = $clog2(OVFL_ENTRIES);
    localparam int CLR_N = (MAIN_ENTRIES > OVFL_ENTRIES) ? MAIN_ENTRIES : OVFL_ENTRIES;
    localparam int CLR_W = $clog2(CLR_N);
    localparam logic [15:0] HW_LIMIT = 16'(COLL_WORDS - COLL_HEADROOM);

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_M_RD    = 14'b00000000000100,
        ST_W_RD    = 14'b00000000001000,
        ST_GL_GO   = 14'b00000000010000,
        ST_GL_RD   = 14'b00000000100000,
        ST_MK_MAIN = 14'b00000001000000,
        ST_MK_LINK = 14'b00000010000000,
        ST_MK_TAIL = 14'b00000100000000,
        ST_RM_A    = 14'b00001000000000,
        ST_RM_B    = 14'b00010000000000,
        ST_RM_C    = 14'b00100000000000,
        ST_OV_CHK  = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } state_t;

    function automatic logic [CI_W-1:0] cidx(logic [15:0] off);
        return off[CI_W:1];
    endfunction

    logic [15:0] main_mem [MAIN_ENTRIES];
    logic [15:0] ent_mem  [COLL_WORDS/2];
    logic [15:0] nxt_mem  [COLL_WORDS/2];
    rcht_pkg::ovfl_t ovfl_mem [OVFL_ENTRIES];

    logic            main_we, ent_we, nxt_we, ovfl_we;
    logic [MI_W-1:0] main_waddr, main_raddr;
    logic [15:0]     main_wdata, main_rd;
    logic [CI_W-1:0] ent_waddr, nxt_waddr, coll_raddr;
    logic [15:0]     ent_wdata, nxt_wdata, ent_rd, nxt_rd;
    logic [OI_W-1:0] ovfl_waddr, ovfl_raddr;
    rcht_pkg::ovfl_t ovfl_wdata, ovfl_rd;

    always_ff @(posedge aclk) begin
        if (main_we) main_mem[main_waddr] <= main_wdata;
        main_rd <= main_mem[main_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        ent_rd <= ent_mem[coll_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
        nxt_rd <= nxt_mem[coll_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ovfl_we) ovfl_mem[ovfl_waddr] <= ovfl_wdata;
        ovfl_rd <= ovfl_mem[ovfl_raddr];
    end

    state_t               state_reg, state_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [23:0]          ptr_reg, ptr_next;
    logic                 rec_reg, rec_next;
    logic [15:0]          word_reg, word_next;
    logic [15:0]          main_cur_reg, main_cur_next;
    logic [15:0]          lk_reg, lk_next;
    logic [15:0]          pv_reg, pv_next;
    logic [15:0]          nxt_lk_reg, nxt_lk_next;
    logic [15:0]          lk_new_reg, lk_new_next;
    logic [15:0]          pv_new_reg, pv_new_next;
    logic [15:0]          free_head_reg, free_head_next;
    logic [15:0]          hw_reg, hw_next;
    logic                 gc_dis_reg, gc_dis_next;
    logic [2:0]           err_reg, err_next;
    logic                 zero_reg, zero_next;
    logic                 loc_main_reg, loc_main_next;
    logic                 enter_reg, enter_next;
    logic [OI_W-1:0]      oi_reg, oi_next;
    rcht_pkg::gl_mode_t   gl_mode_reg, gl_mode_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    logic [MI_W-1:0]   idx;
    logic [7:0]        tag8;
    logic              can_create;
    logic [23:0]       q_ptr;
    logic              ov_last;
    rcht_pkg::mod_res_t mr;
    logic              wr_loc, wr_main;
    logic [15:0]       wr_word, got, h_off;

    assign idx        = ptr_reg[MI_W:1];
    assign tag8       = ptr_reg[23:16];
    assign can_create = (cmd_reg != rcht_pkg::CMD_STK) || rec_reg;
    assign q_ptr      = {ptr_reg[23:1], 1'b0};
    assign ov_last    = (oi_reg == OI_W'(OVFL_ENTRIES - 1));
    assign h_off      = main_cur_reg - 16'd1;
    assign main_raddr = s_tdata[MI_W+2:3];
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        rec_next       = rec_reg;
        word_next      = word_reg;
        main_cur_next  = main_cur_reg;
        lk_next        = lk_reg;
        pv_next        = pv_reg;
        nxt_lk_next    = nxt_lk_reg;
        lk_new_next    = lk_new_reg;
        pv_new_next    = pv_new_reg;
        free_head_next = free_head_reg;
        hw_next        = hw_reg;
        gc_dis_next    = gc_dis_reg;
        err_next       = err_reg;
        zero_next      = zero_reg;
        loc_main_next  = loc_main_reg;
        enter_next     = enter_reg;
        oi_next        = oi_reg;
        gl_mode_next   = gl_mode_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_tdata_next   = m_tdata_reg;

        main_we    = 1'b0;
        main_waddr = idx;
        main_wdata = 16'd0;
        ent_we     = 1'b0;
        ent_waddr  = cidx(lk_reg);
        ent_wdata  = 16'd0;
        nxt_we     = 1'b0;
        nxt_waddr  = cidx(lk_reg);
        nxt_wdata  = 16'd0;
        coll_raddr = cidx(lk_reg);
        ovfl_we    = 1'b0;
        ovfl_waddr = oi_reg;
        ovfl_wdata = ovfl_rd;
        ovfl_raddr = oi_reg;

        wr_loc  = 1'b0;
        wr_main = loc_main_reg;
        wr_word = word_reg;
        got     = hw_reg;
        mr      = rcht_pkg::mod_entry((state_reg == ST_M_RD) ? main_rd : ent_rd,
                                      cmd_reg, rec_reg);

        unique case (state_reg)
            ST_CLEAR: begin
                if ({1'b0, clr_reg} < (CLR_W+1)'(MAIN_ENTRIES)) begin
                    main_we    = 1'b1;
                    main_waddr = clr_reg[MI_W-1:0];
                end
                if ({1'b0, clr_reg} < (CLR_W+1)'(OVFL_ENTRIES)) begin
                    ovfl_we    = 1'b1;
                    ovfl_waddr = clr_reg[OI_W-1:0];
                    ovfl_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_N - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tdata[1:0];
                    ptr_next  = s_tdata[25:2];
                    rec_next  = s_tdata[26];
                    err_next  = rcht_pkg::ERR_OK;
                    zero_next = 1'b0;
                    if (gc_dis_reg) begin
                        state_next = ST_DONE;
                    end else if (s_tdata[1:0] == rcht_pkg::CMD_BAD) begin
                        err_next   = rcht_pkg::ERR_STACK;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_M_RD;
                    end
                end
            end
            ST_M_RD: begin
                loc_main_next = 1'b1;
                wr_main       = 1'b1;
                word_next     = main_rd;
                if (main_rd == 16'd0) begin
                    state_next = ST_DONE;
                    if (!can_create) begin
                        err_next = rcht_pkg::ERR_STACK;
                    end else begin
                        main_we    = 1'b1;
                        main_wdata = rcht_pkg::new_value(cmd_reg, tag8);
                        zero_next  = (cmd_reg == rcht_pkg::CMD_DEL);
                    end
                end else if (!main_rd[0]) begin
                    if (main_rd[8:1] == tag8) begin
                        unique case (mr.act)
                            rcht_pkg::ACT_WRITE: begin
                                wr_loc     = 1'b1;
                                wr_word    = mr.word;
                                state_next = ST_DONE;
                            end
                            rcht_pkg::ACT_BIG_ENTER: begin
                                wr_loc     = 1'b1;
                                wr_word    = mr.word;
                                word_next  = mr.word;
                                enter_next = 1'b1;
                                oi_next    = '0;
                                ovfl_raddr = '0;
                                state_next = ST_OV_CHK;
                            end
                            rcht_pkg::ACT_BIG_MOD: begin
                                enter_next = 1'b0;
                                oi_next    = '0;
                                ovfl_raddr = '0;
                                state_next = ST_OV_CHK;
                            end
                            rcht_pkg::ACT_REMOVE: begin
                                wr_loc     = 1'b1;
                                wr_word    = 16'd0;
                                state_next = ST_DONE;
                            end
                            default: begin
                                err_next   = mr.err;
                                state_next = ST_DONE;
                            end
                        endcase
                    end else if (!can_create) begin
                        err_next   = rcht_pkg::ERR_STACK;
                        state_next = ST_DONE;
                    end else begin
                        gl_mode_next = rcht_pkg::GLM_COLL1;
                        state_next   = ST_GL_GO;
                    end
                end else begin
                    main_cur_next = main_rd;
                    lk_next       = main_rd - 16'd1;
                    pv_next       = 16'd0;
                    coll_raddr    = cidx(main_rd - 16'd1);
                    state_next    = ST_W_RD;
                end
            end
            ST_W_RD: begin
                loc_main_next = 1'b0;
                wr_main       = 1'b0;
                word_next     = ent_rd;
                if (ent_rd[8:1] == tag8) begin
                    unique case (mr.act)
                        rcht_pkg::ACT_WRITE: begin
                            wr_loc     = 1'b1;
                            wr_word    = mr.word;
                            state_next = ST_DONE;
                        end
                        rcht_pkg::ACT_BIG_ENTER: begin
                            wr_loc     = 1'b1;
                            wr_word    = mr.word;
                            word_next  = mr.word;
                            enter_next = 1'b1;
                            oi_next    = '0;
                            ovfl_raddr = '0;
                            state_next = ST_OV_CHK;
                        end
                        rcht_pkg::ACT_BIG_MOD: begin
                            enter_next = 1'b0;
                            oi_next    = '0;
                            ovfl_raddr = '0;
                            state_next = ST_OV_CHK;
                        end
                        rcht_pkg::ACT_REMOVE: begin
                            nxt_lk_next = nxt_rd;
                            state_next  = ST_RM_A;
                        end
                        default: begin
                            err_next   = mr.err;
                            state_next = ST_DONE;
                        end
                    endcase
                end else if (nxt_rd != 16'd0) begin
                    pv_next    = lk_reg;
                    lk_next    = nxt_rd;
                    coll_raddr = cidx(nxt_rd);
                end else if (!can_create) begin
                    err_next   = rcht_pkg::ERR_STACK;
                    state_next = ST_DONE;
                end else begin
                    gl_mode_next = rcht_pkg::GLM_TAIL;
                    state_next   = ST_GL_GO;
                end
            end
            ST_GL_GO, ST_GL_RD: begin
                if (state_reg == ST_GL_GO && free_head_reg != 16'd0) begin
                    coll_raddr = cidx(free_head_reg);
                    state_next = ST_GL_RD;
                end else if (state_reg == ST_GL_GO && hw_reg >= HW_LIMIT) begin
                    gc_dis_next = 1'b1;
                    err_next    = rcht_pkg::ERR_COLL_FULL;
                    state_next  = ST_DONE;
                end else begin
                    if (state_reg == ST_GL_GO) begin
                        got     = hw_reg;
                        hw_next = hw_reg + 16'd2;
                    end else begin
                        got            = free_head_reg;
                        free_head_next = nxt_rd;
                    end
                    unique case (gl_mode_reg)
                        rcht_pkg::GLM_COLL1: begin
                            lk_new_next  = got;
                            gl_mode_next = rcht_pkg::GLM_COLL2;
                            state_next   = ST_GL_GO;
                        end
                        rcht_pkg::GLM_COLL2: begin
                            pv_new_next = got;
                            state_next  = ST_MK_MAIN;
                        end
                        default: begin
                            lk_new_next = got;
                            state_next  = ST_MK_TAIL;
                        end
                    endcase
                end
            end
            ST_MK_MAIN: begin
                ent_we     = 1'b1;
                ent_waddr  = cidx(pv_new_reg);
                ent_wdata  = word_reg;
                nxt_we     = 1'b1;
                nxt_waddr  = cidx(pv_new_reg);
                nxt_wdata  = 16'd0;
                main_we    = 1'b1;
                main_wdata = lk_new_reg + 16'd1;
                state_next = ST_MK_LINK;
            end
            ST_MK_LINK: begin
                ent_we     = 1'b1;
                ent_waddr  = cidx(lk_new_reg);
                ent_wdata  = rcht_pkg::new_value(cmd_reg, tag8);
                nxt_we     = 1'b1;
                nxt_waddr  = cidx(lk_new_reg);
                nxt_wdata  = pv_new_reg;
                zero_next  = (cmd_reg == rcht_pkg::CMD_DEL);
                state_next = ST_DONE;
            end
            ST_MK_TAIL: begin
                ent_we     = 1'b1;
                ent_waddr  = cidx(lk_new_reg);
                ent_wdata  = rcht_pkg::new_value(cmd_reg, tag8);
                nxt_we     = 1'b1;
                nxt_waddr  = cidx(lk_new_reg);
                nxt_wdata  = main_cur_reg - 16'd1;
                main_we    = 1'b1;
                main_wdata = lk_new_reg + 16'd1;
                zero_next  = (cmd_reg == rcht_pkg::CMD_DEL);
                state_next = ST_DONE;
            end
            ST_RM_A: begin
                if (pv_reg != 16'd0) begin
                    nxt_we    = 1'b1;
                    nxt_waddr = cidx(pv_reg);
                    nxt_wdata = nxt_lk_reg;
                end else begin
                    main_we       = 1'b1;
                    main_wdata    = nxt_lk_reg | 16'd1;
                    main_cur_next = nxt_lk_reg | 16'd1;
                end
                state_next = ST_RM_B;
            end
            ST_RM_B: begin
                nxt_we         = 1'b1;
                nxt_waddr      = cidx(lk_reg);
                nxt_wdata      = free_head_reg;
                free_head_next = lk_reg;
                coll_raddr     = cidx(h_off);
                state_next     = ST_RM_C;
            end
            ST_RM_C: begin
                if (nxt_rd == 16'd0) begin
                    main_we        = 1'b1;
                    main_wdata     = ent_rd;
                    nxt_we         = 1'b1;
                    nxt_waddr      = cidx(h_off);
                    nxt_wdata      = free_head_reg;
                    free_head_next = h_off;
                end
                state_next = ST_DONE;
            end
            ST_OV_CHK: begin
                state_next = ST_DONE;
                if (enter_reg) begin
                    if (ovfl_rd.tag != rcht_pkg::OTAG_USED) begin
                        ovfl_we    = 1'b1;
                        ovfl_wdata = '{tag: rcht_pkg::OTAG_USED, ptr: q_ptr,
                                       cnt: rcht_pkg::BIG_LIMIT};
                    end else if (ovfl_rd.ptr == q_ptr) begin
                        err_next       = rcht_pkg::ERR_OVFL_DUP;
                        ovfl_we        = 1'b1;
                        ovfl_wdata.cnt = ovfl_rd.cnt + rcht_pkg::BIG_DUP;
                    end else if (ov_last) begin
                        err_next = rcht_pkg::ERR_OVFL_FULL;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        ovfl_raddr = oi_reg + 1'b1;
                        state_next = ST_OV_CHK;
                    end
                end else begin
                    if (ovfl_rd.tag == rcht_pkg::OTAG_END) begin
                        err_next = rcht_pkg::ERR_OVFL_MISS;
                    end else if (ovfl_rd.tag == rcht_pkg::OTAG_USED && ovfl_rd.ptr == q_ptr) begin
                        unique case (cmd_reg)
                            rcht_pkg::CMD_ADD: begin
                                ovfl_we        = 1'b1;
                                ovfl_wdata.cnt = ovfl_rd.cnt + 32'd1;
                            end
                            rcht_pkg::CMD_DEL: begin
                                ovfl_we        = 1'b1;
                                ovfl_wdata.cnt = ovfl_rd.cnt - 32'd1;
                                if (ovfl_rd.cnt <= rcht_pkg::BIG_LIMIT) begin
                                    ovfl_wdata.tag = rcht_pkg::OTAG_FREE;
                                    wr_loc  = 1'b1;
                                    wr_word = (word_reg & rcht_pkg::LOW_MASK)
                                              | rcht_pkg::CNT_FALL;
                                end
                            end
                            default: begin
                                wr_loc  = 1'b1;
                                wr_word = word_reg | rcht_pkg::STK_BIT;
                            end
                        endcase
                    end else if (ov_last) begin
                        err_next = rcht_pkg::ERR_OVFL_MISS;
                    end else begin
                        oi_next    = oi_reg + 1'b1;
                        ovfl_raddr = oi_reg + 1'b1;
                        state_next = ST_OV_CHK;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, gc_dis_reg, err_reg,
                                     zero_reg ? ptr_reg : 24'd0, zero_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (wr_loc) begin
            if (wr_main) begin
                main_we    = 1'b1;
                main_waddr = idx;
                main_wdata = wr_word;
            end else begin
                ent_we    = 1'b1;
                ent_waddr = cidx(lk_reg);
                ent_wdata = wr_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= 16'd0;
            hw_reg        <= 16'd2;
            gc_dis_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            gl_mode_reg   <= rcht_pkg::GLM_COLL1;
            enter_reg     <= 1'b0;
            loc_main_reg  <= 1'b1;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            hw_reg        <= hw_next;
            gc_dis_reg    <= gc_dis_next;
            m_tvalid_reg  <= m_tvalid_next;
            gl_mode_reg   <= gl_mode_next;
            enter_reg     <= enter_next;
            loc_main_reg  <= loc_main_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ptr_reg      <= ptr_next;
        rec_reg      <= rec_next;
        word_reg     <= word_next;
        main_cur_reg <= main_cur_next;
        lk_reg       <= lk_next;
        pv_reg       <= pv_next;
        nxt_lk_reg   <= nxt_lk_next;
        lk_new_reg   <= lk_new_next;
        pv_new_reg   <= pv_new_next;
        err_reg      <= err_next;
        zero_reg     <= zero_next;
        oi_reg       <= oi_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

@@ tb/rcht_checker.sv @@
module rcht_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          zero_seen,
    output int          err_seen [0:7]
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAIN = rcht_pkg::MAIN_ENTRIES_DEF;
    localparam int NCOLL = rcht_pkg::COLL_WORDS_DEF;
    localparam int NHEAD = rcht_pkg::COLL_HEADROOM_DEF;
    localparam int NOVFL = rcht_pkg::OVFL_ENTRIES_DEF;

    typedef struct packed {
        logic        zero_valid;
        logic [23:0] zero_ptr;
        logic [2:0]  err;
        logic        gc_off;
    } outcome_t;

    logic [15:0] main_tbl   [0:NMAIN-1];
    logic [15:0] coll_store [0:NCOLL-1];
    logic [15:0] free_head;
    logic [15:0] high_water;
    logic [1:0]  big_tag    [0:NOVFL-1];
    logic [23:0] big_ptr    [0:NOVFL-1];
    logic [31:0] big_cnt    [0:NOVFL-1];
    logic [31:0] alloc_cnt;
    logic        gc_dis;
    logic [2:0]  cur_err;
    logic        cur_zero;
    outcome_t    outcome_q [$];

    function automatic int unsigned slot(int unsigned a);
        return a % NCOLL;
    endfunction

    function automatic bit take_link(output int unsigned off);
        off = 0;
        if (free_head == 0) begin
            if (int'(high_water) >= NCOLL - NHEAD) begin
                gc_dis  = 1'b1;
                cur_err = rcht_pkg::ERR_COLL_FULL;
                return 1'b0;
            end
            off        = high_water;
            high_water = high_water + 16'd2;
        end else begin
            off       = free_head;
            free_head = coll_store[slot(int'(free_head) + 1)];
        end
        return 1'b1;
    endfunction

    function automatic void give_link(int unsigned off);
        coll_store[slot(off + 1)] = free_head;
        free_head = off[15:0];
    endfunction

    function automatic void ovfl_enter(logic [23:0] p);
        logic [23:0] q;
        int i;
        q = p & 24'hFFFFFE;
        for (i = 0; i < NOVFL; i++) begin
            if (big_tag[i] != rcht_pkg::OTAG_USED) break;
            if (big_ptr[i] == q) begin
                cur_err    = rcht_pkg::ERR_OVFL_DUP;
                big_cnt[i] = big_cnt[i] + rcht_pkg::BIG_DUP;
                return;
            end
        end
        if (i >= NOVFL) begin
            cur_err = rcht_pkg::ERR_OVFL_FULL;
            return;
        end
        big_tag[i] = rcht_pkg::OTAG_USED;
        big_ptr[i] = q;
        big_cnt[i] = rcht_pkg::BIG_LIMIT;
    endfunction

    function automatic void ovfl_modify(inout logic [15:0] w, input logic [1:0] cmd,
                                        input logic [23:0] p);
        logic [23:0] q;
        int i;
        q = p & 24'hFFFFFE;
        for (i = 0; i < NOVFL; i++) begin
            if (big_tag[i] == rcht_pkg::OTAG_END) break;
            if (big_tag[i] == rcht_pkg::OTAG_USED && big_ptr[i] == q) break;
        end
        if (i >= NOVFL || big_tag[i] != rcht_pkg::OTAG_USED) begin
            cur_err = rcht_pkg::ERR_OVFL_MISS;
            return;
        end
        if (cmd == rcht_pkg::CMD_ADD) begin
            big_cnt[i] = big_cnt[i] + 32'd1;
        end else if (cmd == rcht_pkg::CMD_DEL) begin
            if (big_cnt[i] <= rcht_pkg::BIG_LIMIT) begin
                w          = (w & rcht_pkg::LOW_MASK) | rcht_pkg::CNT_FALL;
                big_tag[i] = rcht_pkg::OTAG_FREE;
            end
            big_cnt[i] = big_cnt[i] - 32'd1;
        end else begin
            w = w | rcht_pkg::STK_BIT;
        end
    endfunction

    function automatic bit update_entry(inout logic [15:0] w, input logic [1:0] cmd,
                                        input logic rec, input logic [23:0] p);
        logic [16:0] c;
        c = {1'b0, w};
        if (w >= rcht_pkg::CNT_MASK) begin
            ovfl_modify(w, cmd, p);
            return 1'b0;
        end
        if (cmd == rcht_pkg::CMD_ADD) begin
            c = c + rcht_pkg::CNT_ONE;
            if (c >= rcht_pkg::CNT_MASK) begin
                w = c[15:0];
                ovfl_enter(p);
                return 1'b0;
            end
        end else if (cmd == rcht_pkg::CMD_DEL) begin
            if (c < rcht_pkg::CNT_ONE) begin
                cur_err = rcht_pkg::ERR_ZERO_DEC;
                return 1'b0;
            end
            c = c - rcht_pkg::CNT_ONE;
        end else begin
            if (!rec) begin
                cur_err = rcht_pkg::ERR_STACK;
                return 1'b0;
            end
            w = c[15:0] | rcht_pkg::STK_BIT;
            return 1'b0;
        end
        if ((c[15:0] & rcht_pkg::CNT_STK_MASK) == rcht_pkg::CNT_ONE) begin
            if (!rec) alloc_cnt = alloc_cnt - 32'd1;
            return 1'b1;
        end
        w = c[15:0];
        return 1'b0;
    endfunction

    function automatic logic [15:0] fresh_word(logic [1:0] cmd, logic rec, logic [15:0] hi);
        if (!rec) alloc_cnt = alloc_cnt + 32'd1;
        if (cmd == rcht_pkg::CMD_ADD) return hi | rcht_pkg::CNT_TWO;
        if (cmd == rcht_pkg::CMD_DEL) begin
            cur_zero = 1'b1;
            return hi;
        end
        return hi | rcht_pkg::CNT_ONE | rcht_pkg::STK_BIT;
    endfunction

    function automatic void apply_request(logic [1:0] cmd, logic [23:0] p, logic rec);
        int unsigned idx, lk, pv, nl, h, n, nx;
        logic [15:0] hi, c, w;
        bit can_make;
        idx      = p[15:1] % NMAIN;
        hi       = {7'd0, p[23:16], 1'b0};
        c        = main_tbl[idx];
        can_make = (cmd != rcht_pkg::CMD_STK) || rec;
        if (c == 0) begin
            if (!can_make) begin
                cur_err = rcht_pkg::ERR_STACK;
                return;
            end
            main_tbl[idx] = fresh_word(cmd, rec, hi);
            return;
        end
        if (!c[0]) begin
            if ((c & 16'h01FE) == hi) begin
                w = c;
                if (update_entry(w, cmd, rec, p)) main_tbl[idx] = 16'd0;
                else main_tbl[idx] = w;
                return;
            end
            if (!can_make) begin
                cur_err = rcht_pkg::ERR_STACK;
                return;
            end
            if (!take_link(lk)) return;
            if (!take_link(pv)) return;
            coll_store[slot(pv + 1)] = 16'd0;
            coll_store[slot(pv)]     = c;
            coll_store[slot(lk + 1)] = pv[15:0];
            main_tbl[idx]            = lk[15:0] + 16'd1;
            coll_store[slot(lk)]     = fresh_word(cmd, rec, hi);
            return;
        end
        lk = int'(c) - 1;
        pv = 0;
        for (n = 0; n < NCOLL; n++) begin
            if ((coll_store[slot(lk)] & 16'h01FE) == hi) begin
                w = coll_store[slot(lk)];
                if (!update_entry(w, cmd, rec, p)) begin
                    coll_store[slot(lk)] = w;
                    return;
                end
                if (pv != 0) coll_store[slot(pv + 1)] = coll_store[slot(lk + 1)];
                else main_tbl[idx] = coll_store[slot(lk + 1)] | 16'd1;
                give_link(lk);
                h = (int'(main_tbl[idx]) - 1) & 32'hFFFF;
                if (coll_store[slot(h + 1)] == 0) begin
                    main_tbl[idx] = coll_store[slot(h)];
                    give_link(h);
                end
                return;
            end
            nx = coll_store[slot(lk + 1)];
            if (nx == 0) break;
            pv = lk;
            lk = nx;
        end
        if (!can_make) begin
            cur_err = rcht_pkg::ERR_STACK;
            return;
        end
        if (!take_link(nl)) return;
        coll_store[slot(nl + 1)] = main_tbl[idx] - 16'd1;
        main_tbl[idx]            = nl[15:0] + 16'd1;
        coll_store[slot(nl)]     = fresh_word(cmd, rec, hi);
    endfunction

    function automatic outcome_t predict_outcome(logic [31:0] req);
        outcome_t o;
        cur_err  = rcht_pkg::ERR_OK;
        cur_zero = 1'b0;
        if (!gc_dis) begin
            if (req[1:0] == rcht_pkg::CMD_BAD) cur_err = rcht_pkg::ERR_STACK;
            else apply_request(req[1:0], req[25:2], req[26]);
        end
        o.zero_valid = cur_zero;
        o.zero_ptr   = cur_zero ? req[25:2] : 24'd0;
        o.err        = cur_err;
        o.gc_off     = gc_dis;
        return o;
    endfunction

    initial begin
        for (int i = 0; i < NMAIN; i++) main_tbl[i] = 16'd0;
        for (int i = 0; i < NCOLL; i++) coll_store[i] = 16'd0;
        for (int i = 0; i < NOVFL; i++) begin
            big_tag[i] = rcht_pkg::OTAG_END;
            big_ptr[i] = 24'd0;
            big_cnt[i] = 32'd0;
        end
        free_head  = 16'd0;
        high_water = 16'd2;
        alloc_cnt  = 32'd0;
        gc_dis     = 1'b0;
    end

    always @(posedge aclk) begin
        outcome_t got, want;
        if (!aresetn) begin
            fail_count = 0;
            zero_seen  = 0;
            for (int i = 0; i < 8; i++) err_seen[i] = 0;
        end
        if (aresetn && s_tvalid && s_tready) begin
            outcome_q.push_back(predict_outcome(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = outcome_t'({m_tdata[0], m_tdata[24:1], m_tdata[27:25], m_tdata[28]});
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no request waiting: %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = outcome_q.pop_front();
                if (got.zero_valid !== want.zero_valid) begin
                    $display("%0t: zero_entry_valid exp %0d got %0d", $time,
                             want.zero_valid, got.zero_valid);
                    fail_count++;
                end
                if (got.zero_ptr !== want.zero_ptr) begin
                    $display("%0t: zero_pointer exp %h got %h", $time,
                             want.zero_ptr, got.zero_ptr);
                    fail_count++;
                end
                if (got.err !== want.err) begin
                    $display("%0t: error_code exp %0d got %0d", $time, want.err, got.err);
                    fail_count++;
                end
                if (got.gc_off !== want.gc_off) begin
                    $display("%0t: gc_off exp %0d got %0d", $time, want.gc_off, got.gc_off);
                    fail_count++;
                end
                if (want.zero_valid) zero_seen++;
                err_seen[want.err]++;
            end
        end
        pending = outcome_q.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    int          zero_seen;
    int          err_seen [0:7];
    int          idle_cycles = 0;
    int          burst_left;
    int          sent;
    int          stall_mode = 0;
    int          stall_left = 0;

    refcount_hash_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rcht_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .zero_seen  (zero_seen),
        .err_seen   (err_seen)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: alternate between no stalls, light stalls and heavy stalls
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(logic [1:0] cmd, logic [23:0] ptr, logic rec);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            if (s_tvalid) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                gap--;
            end
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, rec, ptr, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) return rcht_pkg::CMD_ADD;
        if (r < 80) return rcht_pkg::CMD_DEL;
        if (r < 97) return rcht_pkg::CMD_STK;
        return rcht_pkg::CMD_BAD;
    endfunction

    function automatic logic [7:0] pick_tag();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [23:0] p;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 32'd0;
        burst_left  = 0;
        sent        = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, each command, collisions and folding
        send(rcht_pkg::CMD_ADD, 24'h000000, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'h000000, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'h000000, 1'b0);
        send(rcht_pkg::CMD_ADD, 24'hFFFFFF, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'hFFFFFF, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'hFFFFFF, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'hFFFFFF, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'h12ABCE, 1'b0);
        send(rcht_pkg::CMD_STK, 24'h345670, 1'b0);
        send(rcht_pkg::CMD_STK, 24'h345670, 1'b1);
        send(rcht_pkg::CMD_STK, 24'h345670, 1'b0);
        send(rcht_pkg::CMD_BAD, 24'h555555, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'h00AAAA, 1'b0);
        send(rcht_pkg::CMD_ADD, 24'h00AAAA, 1'b0);
        send(rcht_pkg::CMD_ADD, 24'h01AAAA, 1'b0);
        send(rcht_pkg::CMD_ADD, 24'h02AAAB, 1'b0);
        send(rcht_pkg::CMD_ADD, 24'h03AAAA, 1'b1);
        send(rcht_pkg::CMD_DEL, 24'h02AAAA, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'h01AAAA, 1'b0);
        send(rcht_pkg::CMD_STK, 24'h03AAAA, 1'b0);
        send(rcht_pkg::CMD_DEL, 24'h03AAAA, 1'b1);
        send(rcht_pkg::CMD_DEL, 24'h01AAAA, 1'b1);
        send(rcht_pkg::CMD_ADD, 24'h7E5432, 1'b1);
        send(rcht_pkg::CMD_DEL, 24'h7E5432, 1'b1);
        drain();

        // random traffic on a few crowded slots
        for (int i = 0; i < 360; i++) begin
            if ($urandom_range(0, 9) == 0) p = 24'($urandom());
            else p = {pick_tag(), 4'h1, 8'($urandom_range(0, 7) * 2), 3'd0,
                      1'($urandom_range(0, 1))};
            send(pick_cmd(), p, $urandom_range(0, 3) == 0);
        end

        // drive two counts into the overflow table, then add, stick and delete; two deletes bring one back out
        for (int k = 0; k < 2; k++) begin
            p = {8'hA5, 16'(16'h4000 + 2 * k)};
            repeat (62) send(rcht_pkg::CMD_ADD, p, 1'b0);
        end
        for (int k = 0; k < 2; k++) begin
            p = {8'hA5, 16'(16'h4000 + 2 * k)};
            send(rcht_pkg::CMD_ADD, p | 24'd1, 1'b0);
            send(rcht_pkg::CMD_STK, p, 1'b0);
            repeat ($urandom_range(1, 4)) send(rcht_pkg::CMD_DEL, p, 1'b0);
            send(rcht_pkg::CMD_ADD, p, $urandom_range(0, 1));
        end

        for (int i = 0; i < 20; i++) begin
            send(pick_cmd(), 24'($urandom()), $urandom_range(0, 1));
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("sent %0d requests over chains, folding and overflow; %0d zero entries",
                 sent, zero_seen);
        $display("  error codes ok/stk/zdec/dup/miss/full/coll: %0d %0d %0d %0d %0d %0d %0d",
                 err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4],
                 err_seen[5], err_seen[6]);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rcht_pkg.sv
hw/rtl/refcount_hash_table.sv
tb/rcht_checker.sv
tb/testbench.sv
